>>> rtl/core/lpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpg_pkg;

  // default bound on the number of symbols
  localparam int unsigned MAX_LEN_DEF = 8;

  // field widths
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned SYM_W  = 4;
  localparam int unsigned SLOT_W = 3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIV,
    ST_SUCC,
    ST_SWAP_J,
    ST_SWAP_P,
    ST_REV_RD,
    ST_REV_WL,
    ST_REV_WH,
    ST_EMIT,
    ST_EXH
  } lpg_state_t;

  typedef struct packed {
    logic [SYM_W-1:0]  symbol_value;
    logic [SLOT_W-1:0] slot_index;
    logic              last_of_run;
    logic              exhausted;
  } lpg_beat_t;

endpackage

`default_nettype wire

>>> rtl/core/lpg_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lpg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lpg_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lpg_res_if;
  logic                           valid;
  logic                           ready;
  logic [lpg_pkg::SYM_W-1:0]      symbol_value;
  logic [lpg_pkg::SLOT_W-1:0]     slot_index;
  logic                           last_of_run;
  logic                           exhausted;

  modport source (output valid, output symbol_value, output slot_index,
                  output last_of_run, output exhausted, input ready);
  modport sink (input valid, input symbol_value, input slot_index,
                input last_of_run, input exhausted, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lexicographic_permutation_generator.sv
// Lexicographic permutation generator. Each request beat on in_if produces the
// next permutation of the symbols 1..n as n result beats on out_if, position 0
// first, with last_of_run set on the final beat; restart=1 (or the first request
// after reset or after a length write) produces the identity. Once every
// permutation has gone out, each further request produces a single beat with
// exhausted=1 and symbol_value 0. n comes from the cfg_wr_data write (0 acts as
// 1, values above MAX_LEN act as MAX_LEN); a length write restarts the sequence.
// The permutation lives in a small synchronous RAM with one write port and two
// registered read ports, so a request goes through an accept in idle, a pivot
// scan from the right, a successor scan, two swap writes, a suffix reversal
// that reads one swapped pair and writes back each half in turn, and the
// readout; a repeated exhausted request skips to its single beat and the
// identity skips to the readout. The one RAM write port sets the swap and
// reversal cost. A two-beat output queue lets the readout run ahead of a slow
// sink and lets the next request be taken while results still wait.
`timescale 1ns / 1ps
`default_nettype none

module lexicographic_permutation_generator #(
  parameter int unsigned MAX_LEN = lpg_pkg::MAX_LEN_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [lpg_pkg::LEN_W-1:0]  cfg_wr_data,
  lpg_req_if.sink                         in_if,
  lpg_res_if.source                       out_if
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LW = lpg_pkg::LEN_W;
  localparam int unsigned SW = lpg_pkg::SYM_W;
  localparam int unsigned TW = lpg_pkg::SLOT_W;
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);

  // ---------------------------------------------------------------------------
  // control and datapath registers
  // ---------------------------------------------------------------------------
  lpg_pkg::lpg_state_t state_r, state_nxt;

  logic [LW-1:0]      len_r, len_nxt;         // configured length, raw
  logic               started_r, started_nxt;
  logic               done_r, done_nxt;
  logic [MAX_LEN-1:0] vld_r, vld_nxt;         // entry written since identity load

  logic [AW-1:0]      ptr_r, ptr_nxt;         // scan / readout address
  logic [SW-1:0]      prev_r, prev_nxt;       // right neighbor during pivot scan
  logic [AW-1:0]      piv_r, piv_nxt;
  logic [SW-1:0]      pval_r, pval_nxt;
  logic [AW-1:0]      j_r, j_nxt;
  logic [SW-1:0]      jval_r, jval_nxt;
  logic [AW-1:0]      lo_r, lo_nxt;
  logic [AW-1:0]      hi_r, hi_nxt;
  logic [SW-1:0]      tmp_r, tmp_nxt;

  // read pipeline tags
  logic               da_vld_r;               // port a data present this cycle
  logic               em_tag_r;               // that data belongs to the readout

  // ---------------------------------------------------------------------------
  // permutation store
  // ---------------------------------------------------------------------------
  logic [SW-1:0] mem [MAX_LEN];

  logic          rda_en;
  logic [AW-1:0] rda_addr;
  logic [AW-1:0] rdb_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [SW-1:0] mem_wdata;

  logic [SW-1:0] rda_q, rdb_q;
  logic          va_q, vb_q;
  logic [AW-1:0] ia_q, ib_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rda_q <= mem[rda_addr];
    rdb_q <= mem[rdb_addr];
    va_q  <= vld_r[rda_addr];
    vb_q  <= vld_r[rdb_addr];
    ia_q  <= rda_addr;
    ib_q  <= rdb_addr;
  end

  // entries never written since the last identity load read as index+1
  logic [SW-1:0] val_a, val_b;
  assign val_a = va_q ? rda_q : (SW'(ia_q) + SW'(1));
  assign val_b = vb_q ? rdb_q : (SW'(ib_q) + SW'(1));

  // ---------------------------------------------------------------------------
  // effective length
  // ---------------------------------------------------------------------------
  logic [LW-1:0] eff_len;
  logic [AW-1:0] top_idx;
  logic          one_sym;

  always_comb begin
    if (len_r == '0) begin
      eff_len = LW'(1);
    end else if (len_r > LEN_MAX) begin
      eff_len = LEN_MAX;
    end else begin
      eff_len = len_r;
    end
  end

  assign top_idx = AW'(eff_len - LW'(1));
  assign one_sym = (eff_len == LW'(1));

  // ---------------------------------------------------------------------------
  // output queue, two beats
  // ---------------------------------------------------------------------------
  lpg_pkg::lpg_beat_t q_r [2];
  logic               wp_r, rp_r;
  logic [1:0]         cnt_r;

  logic               push, pop, pend, exh_push;
  lpg_pkg::lpg_beat_t push_beat;
  logic [2:0]         occ;
  logic               space;

  assign pop   = (cnt_r != 2'd0) && out_if.ready;
  assign pend  = da_vld_r && em_tag_r;
  assign occ   = 3'(cnt_r) + 3'(pend) - 3'(pop);
  assign space = (occ < 3'd2);

  assign push = pend || exh_push;

  always_comb begin
    if (pend) begin
      push_beat.symbol_value = val_a;
      push_beat.slot_index   = TW'(ia_q);
      push_beat.last_of_run  = (ia_q == top_idx);
      push_beat.exhausted    = 1'b0;
    end else begin
      push_beat.symbol_value = '0;
      push_beat.slot_index   = '0;
      push_beat.last_of_run  = 1'b1;
      push_beat.exhausted    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_beat;
    end
  end

  assign out_if.valid        = (cnt_r != 2'd0);
  assign out_if.symbol_value = q_r[rp_r].symbol_value;
  assign out_if.slot_index   = q_r[rp_r].slot_index;
  assign out_if.last_of_run  = q_r[rp_r].last_of_run;
  assign out_if.exhausted    = q_r[rp_r].exhausted;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  logic [AW-1:0] piv_inc, lo_inc, hi_dec;
  assign piv_inc = piv_r + AW'(1);
  assign lo_inc  = lo_r + AW'(1);
  assign hi_dec  = hi_r - AW'(1);

  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    started_nxt = started_r;
    done_nxt    = done_r;
    vld_nxt     = vld_r;
    ptr_nxt     = ptr_r;
    prev_nxt    = prev_r;
    piv_nxt     = piv_r;
    pval_nxt    = pval_r;
    j_nxt       = j_r;
    jval_nxt    = jval_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    tmp_nxt     = tmp_r;

    in_if.ready = 1'b0;
    rda_en      = 1'b0;
    rda_addr    = ptr_r;
    rdb_addr    = hi_r;
    mem_we      = 1'b0;
    mem_waddr   = j_r;
    mem_wdata   = pval_r;
    exh_push    = 1'b0;

    unique case (state_r)
      lpg_pkg::ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          if (in_if.restart || !started_r) begin
            // back to identity
            vld_nxt     = '0;
            started_nxt = 1'b1;
            done_nxt    = 1'b0;
            ptr_nxt     = '0;
            state_nxt   = lpg_pkg::ST_EMIT;
          end else if (done_r) begin
            state_nxt = lpg_pkg::ST_EXH;
          end else if (one_sym) begin
            done_nxt  = 1'b1;
            state_nxt = lpg_pkg::ST_EXH;
          end else begin
            ptr_nxt   = top_idx;
            state_nxt = lpg_pkg::ST_PIV;
          end
        end
      end

      // walk right to left for the first ascent
      lpg_pkg::ST_PIV: begin
        rda_en = 1'b1;
        if (ptr_r != '0) begin
          ptr_nxt = ptr_r - AW'(1);
        end
        if (da_vld_r) begin
          if (ia_q == top_idx) begin
            prev_nxt = val_a;
          end else if (val_a < prev_r) begin
            rda_en    = 1'b0;
            piv_nxt   = ia_q;
            pval_nxt  = val_a;
            ptr_nxt   = top_idx;
            state_nxt = lpg_pkg::ST_SUCC;
          end else begin
            prev_nxt = val_a;
            if (ia_q == '0) begin
              // fully descending: last permutation already out
              rda_en    = 1'b0;
              done_nxt  = 1'b1;
              state_nxt = lpg_pkg::ST_EXH;
            end
          end
        end
      end

      // rightmost entry larger than the pivot
      lpg_pkg::ST_SUCC: begin
        rda_en = 1'b1;
        if (ptr_r != '0) begin
          ptr_nxt = ptr_r - AW'(1);
        end
        if (da_vld_r && (val_a > pval_r)) begin
          rda_en    = 1'b0;
          j_nxt     = ia_q;
          jval_nxt  = val_a;
          state_nxt = lpg_pkg::ST_SWAP_J;
        end
      end

      lpg_pkg::ST_SWAP_J: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = pval_r;
        state_nxt = lpg_pkg::ST_SWAP_P;
      end

      lpg_pkg::ST_SWAP_P: begin
        mem_we    = 1'b1;
        mem_waddr = piv_r;
        mem_wdata = jval_r;
        lo_nxt    = piv_inc;
        hi_nxt    = top_idx;
        ptr_nxt   = '0;
        if (piv_inc < top_idx) begin
          state_nxt = lpg_pkg::ST_REV_RD;
        end else begin
          state_nxt = lpg_pkg::ST_EMIT;
        end
      end

      // suffix reversal, one pair at a time: read both ends, write low, write high
      lpg_pkg::ST_REV_RD: begin
        rda_en    = 1'b1;
        rda_addr  = lo_r;
        rdb_addr  = hi_r;
        state_nxt = lpg_pkg::ST_REV_WL;
      end

      lpg_pkg::ST_REV_WL: begin
        mem_we    = 1'b1;
        mem_waddr = lo_r;
        mem_wdata = val_b;
        tmp_nxt   = val_a;
        state_nxt = lpg_pkg::ST_REV_WH;
      end

      lpg_pkg::ST_REV_WH: begin
        mem_we    = 1'b1;
        mem_waddr = hi_r;
        mem_wdata = tmp_r;
        lo_nxt    = lo_inc;
        hi_nxt    = hi_dec;
        ptr_nxt   = '0;
        if (lo_inc < hi_dec) begin
          state_nxt = lpg_pkg::ST_REV_RD;
        end else begin
          state_nxt = lpg_pkg::ST_EMIT;
        end
      end

      // readout into the output queue, paced by free slots
      lpg_pkg::ST_EMIT: begin
        if (space) begin
          rda_en = 1'b1;
          if (ptr_r == top_idx) begin
            state_nxt = lpg_pkg::ST_IDLE;
          end else begin
            ptr_nxt = ptr_r + AW'(1);
          end
        end
      end

      lpg_pkg::ST_EXH: begin
        if (space && !pend) begin
          exh_push  = 1'b1;
          state_nxt = lpg_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lpg_pkg::ST_IDLE;
      end
    endcase

    if (mem_we) begin
      vld_nxt[mem_waddr] = 1'b1;
    end

    // length write restarts the sequence
    if (cfg_wr_en) begin
      len_nxt     = cfg_wr_data;
      vld_nxt     = '0;
      started_nxt = 1'b0;
      done_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lpg_pkg::ST_IDLE;
      len_r     <= LW'(1);
      started_r <= 1'b0;
      done_r    <= 1'b0;
      vld_r     <= '0;
      da_vld_r  <= 1'b0;
      em_tag_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      len_r     <= len_nxt;
      started_r <= started_nxt;
      done_r    <= done_nxt;
      vld_r     <= vld_nxt;
      da_vld_r  <= rda_en;
      em_tag_r  <= (state_r == lpg_pkg::ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    prev_r <= prev_nxt;
    piv_r  <= piv_nxt;
    pval_r <= pval_nxt;
    j_r    <= j_nxt;
    jval_r <= jval_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    tmp_r  <= tmp_nxt;
  end

endmodule

`default_nettype wire
